### hw/rtl/sampling_rate_search_top_defines.svh
// Assertion macros for the sampling rate search block.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef SAMPLING_RATE_SEARCH_TOP_DEFINES_SVH
`define SAMPLING_RATE_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/srs_pkg.sv
// Shared types, register map and reset values for the sampling rate search.
// No dependencies.
`default_nettype none

package srs_pkg;

    typedef logic signed [31:0] t_rate;
    typedef logic [31:0]        t_mag;

    // Register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_INITIAL_RATE    = 3'd0,
        REG_MIN_RATE        = 3'd1,
        REG_SMALL_STEP      = 3'd2,
        REG_LARGE_STEP      = 3'd3,
        REG_RETRY_LIMIT     = 3'd4,
        REG_ITERATION_LIMIT = 3'd5
    } t_reg_idx;

    localparam logic [23:0] INITIAL_RATE_RST    = 24'd600;
    localparam logic [23:0] MIN_RATE_RST        = 24'd40;
    localparam logic [15:0] SMALL_STEP_RST      = 16'd20;
    localparam logic [15:0] LARGE_STEP_RST      = 16'd150;
    localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd3;
    localparam logic [7:0]  ITERATION_LIMIT_RST = 8'd100;

    localparam logic [3:0]  RETRY_MAX = 4'hF;
    localparam logic [7:0]  FRAME_MAX = 8'hFF;
    localparam t_rate       RATE_MAX  = 32'sh7FFF_FFFF;
    localparam t_rate       RATE_MIN  = 32'sh8000_0000;

endpackage

`default_nettype wire

### hw/rtl/sampling_rate_search_top.sv
// Sampling rate search top level: frame peak tracking and hill-climb rate step.
// The bin register feeds the step logic, and a frame's result word is registered after it.
// Throughput: one bin word per cycle; a last bin stalls while the result word is stalled.
// Reset (i_rst_n, synchronous, active low): config and state to defaults, search restarted.
// Depends on srs_pkg and sampling_rate_search_top_defines.svh.
`default_nettype none

module sampling_rate_search_top (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // bin channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [31:0]          i_magnitude,
    input  wire logic                 i_last_bin,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output srs_pkg::t_rate            o_next_rate,
    output logic                      o_search_done,
    output srs_pkg::t_rate            o_best_rate,
    output srs_pkg::t_rate            o_highest_rate_seen,
    output srs_pkg::t_mag             o_best_magnitude,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [4:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    import srs_pkg::*;

    `include "sampling_rate_search_top_defines.svh"

    // configuration registers
    logic [23:0] r_initial_rate;
    logic [23:0] r_min_rate;
    logic [15:0] r_small_step;
    logic [15:0] r_large_step;
    logic [3:0]  r_retry_limit;
    logic [7:0]  r_iteration_limit;

    // bin register
    logic        r_in_valid;
    t_mag        r_in_mag;
    logic        r_in_last;

    // search state
    t_rate       r_rate_now,    n_rate_now;
    logic        r_going_down,  n_going_down;
    logic [3:0]  r_retry_count, n_retry_count;
    t_mag        r_frame_peak,  n_frame_peak;
    t_mag        r_prior_peak,  n_prior_peak;
    t_mag        r_top_mag,     n_top_mag;
    t_rate       r_top_rate,    n_top_rate;
    t_rate       r_ceiling,     n_ceiling;
    logic [7:0]  r_frame_count, n_frame_count;

    // result register
    logic        r_out_valid;
    t_rate       r_out_next_rate,  n_out_next_rate;
    logic        r_out_done,       n_out_done;
    t_rate       r_out_ceiling,    n_out_ceiling;
    t_mag        r_out_best,       n_out_best;

    logic        cfg_wr;
    logic        step_fire;
    t_rate       init_rate_s;
    t_mag        peak;
    logic        peak_gt_prior;
    logic        retry_ok;
    logic        rate_gt_min;
    logic [7:0]  frame_count_inc;
    logic        search_done;

    function automatic t_rate sat_up(input t_rate a, input logic [15:0] d);
        logic signed [32:0] s;
        s = {a[31], a} + {17'd0, d};
        return (s[32] != s[31]) ? RATE_MAX : s[31:0];
    endfunction

    function automatic t_rate sat_down(input t_rate a, input logic [15:0] d);
        logic signed [32:0] s;
        s = {a[31], a} - {17'd0, d};
        return (s[32] != s[31]) ? RATE_MIN : s[31:0];
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_rate    <= INITIAL_RATE_RST;
            r_min_rate        <= MIN_RATE_RST;
            r_small_step      <= SMALL_STEP_RST;
            r_large_step      <= LARGE_STEP_RST;
            r_retry_limit     <= RETRY_LIMIT_RST;
            r_iteration_limit <= ITERATION_LIMIT_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_INITIAL_RATE:    r_initial_rate    <= pwdata[23:0];
                REG_MIN_RATE:        r_min_rate        <= pwdata[23:0];
                REG_SMALL_STEP:      r_small_step      <= pwdata[15:0];
                REG_LARGE_STEP:      r_large_step      <= pwdata[15:0];
                REG_RETRY_LIMIT:     r_retry_limit     <= pwdata[3:0];
                REG_ITERATION_LIMIT: r_iteration_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_INITIAL_RATE:    prdata = {8'd0, r_initial_rate};
            REG_MIN_RATE:        prdata = {8'd0, r_min_rate};
            REG_SMALL_STEP:      prdata = {16'd0, r_small_step};
            REG_LARGE_STEP:      prdata = {16'd0, r_large_step};
            REG_RETRY_LIMIT:     prdata = {28'd0, r_retry_limit};
            REG_ITERATION_LIMIT: prdata = {24'd0, r_iteration_limit};
            default:             prdata = 32'd0;
        endcase
    end

    // ---------------- handshakes ----------------
    // A bin that closes no frame never waits on the result side.
    assign step_fire = r_in_valid && !(r_in_last && r_out_valid && i_stall);
    assign o_stall   = r_in_valid && !step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_mag  <= i_magnitude;
            r_in_last <= i_last_bin;
        end
    end

    // ---------------- frame step ----------------
    assign init_rate_s     = $signed({8'd0, r_initial_rate});
    assign peak            = (r_in_mag > r_frame_peak) ? r_in_mag : r_frame_peak;
    assign peak_gt_prior   = peak > r_prior_peak;
    assign retry_ok        = r_retry_count < r_retry_limit;
    assign rate_gt_min     = !r_rate_now[31] && (r_rate_now[30:0] > {7'd0, r_min_rate});
    assign frame_count_inc = (r_frame_count != FRAME_MAX) ? r_frame_count + 8'd1
                                                          : r_frame_count;

    always_comb begin
        n_rate_now      = r_rate_now;
        n_going_down    = r_going_down;
        n_retry_count   = r_retry_count;
        n_frame_peak    = r_frame_peak;
        n_prior_peak    = r_prior_peak;
        n_top_mag       = r_top_mag;
        n_top_rate      = r_top_rate;
        n_ceiling       = r_ceiling;
        n_frame_count   = r_frame_count;
        n_out_next_rate = r_out_next_rate;
        n_out_done      = r_out_done;
        n_out_ceiling   = r_out_ceiling;
        n_out_best      = r_out_best;
        search_done     = 1'b0;

        if (step_fire && !r_in_last) begin
            n_frame_peak = peak;
        end else if (step_fire) begin
            n_frame_peak = '0;
            if (peak > r_top_mag) begin
                n_top_mag  = peak;
                n_top_rate = r_rate_now;
            end
            if (r_rate_now > r_ceiling) begin
                n_ceiling = r_rate_now;
            end

            if (!r_going_down) begin
                if (peak_gt_prior && (r_rate_now < n_ceiling)) begin
                    n_rate_now    = sat_up(r_rate_now, r_small_step);
                    n_retry_count = '0;
                end else if (retry_ok) begin
                    n_rate_now    = sat_up(r_rate_now, r_large_step);
                    n_retry_count = r_retry_count + 4'd1;
                end else begin
                    n_going_down  = 1'b1;
                    n_rate_now    = init_rate_s;
                    n_retry_count = '0;
                end
            end else begin
                if (retry_ok && !peak_gt_prior && rate_gt_min) begin
                    n_rate_now = sat_down(r_rate_now, r_large_step);
                end else if (peak_gt_prior) begin
                    n_rate_now = sat_down(r_rate_now, r_small_step);
                    if (r_retry_count != RETRY_MAX) begin
                        n_retry_count = r_retry_count + 4'd1;
                    end
                end else begin
                    search_done = 1'b1;
                end
            end

            n_prior_peak  = peak;
            n_frame_count = frame_count_inc;
            if (frame_count_inc >= r_iteration_limit) begin
                search_done = 1'b1;
            end

            // report the frame's result, and restart the search if it ends here
            n_out_ceiling   = n_ceiling;
            n_out_best      = n_top_mag;
            n_out_done      = search_done;
            if (search_done) begin
                n_rate_now    = init_rate_s;
                n_ceiling     = init_rate_s;
                n_top_mag     = '0;
                n_prior_peak  = '0;
                n_going_down  = 1'b0;
                n_retry_count = '0;
                n_frame_count = '0;
            end
            n_out_next_rate = n_rate_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_now    <= $signed({8'd0, INITIAL_RATE_RST});
            r_going_down  <= 1'b0;
            r_retry_count <= '0;
            r_frame_peak  <= '0;
            r_prior_peak  <= '0;
            r_top_mag     <= '0;
            r_top_rate    <= $signed({8'd0, INITIAL_RATE_RST});
            r_ceiling     <= $signed({8'd0, INITIAL_RATE_RST});
            r_frame_count <= '0;
        end else begin
            r_rate_now    <= n_rate_now;
            r_going_down  <= n_going_down;
            r_retry_count <= n_retry_count;
            r_frame_peak  <= n_frame_peak;
            r_prior_peak  <= n_prior_peak;
            r_top_mag     <= n_top_mag;
            r_top_rate    <= n_top_rate;
            r_ceiling     <= n_ceiling;
            r_frame_count <= n_frame_count;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && r_in_last) begin
            r_out_next_rate <= n_out_next_rate;
            r_out_done      <= n_out_done;
            r_out_ceiling   <= n_out_ceiling;
            r_out_best      <= n_out_best;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_next_rate         = r_out_next_rate;
    assign o_search_done       = r_out_done;
    assign o_best_rate         = r_top_rate;
    assign o_highest_rate_seen = r_out_ceiling;
    assign o_best_magnitude    = r_out_best;

    // ---------------- assertions ----------------
    `SRS_ASSERT_NEXT(a_restart_on_done, step_fire && r_in_last && search_done, !r_going_down && (r_frame_count == 8'd0) && (r_top_mag == '0), "search state not restarted after a finishing frame")
    `SRS_ASSERT_NEXT(a_no_word_mid_frame, step_fire && !r_in_last && !(r_out_valid && i_stall), !o_valid, "result word raised for a bin that closes no frame")
    `SRS_ASSERT_SAME(a_done_rate_initial, o_valid && o_search_done, o_next_rate == init_rate_s, "finishing frame does not restart from the initial rate")

endmodule

`default_nettype wire
